@@ design/bes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bes_pkg;

   localparam int unsigned DelayWidth  = 16;
   localparam int unsigned TimeWidth   = 32;
   localparam int unsigned CountWidth  = 32;
   localparam int unsigned CountNum    = 5;
   localparam int unsigned CsrIdxWidth = 3;

   typedef enum logic [3:0] {
      STAGE_OFF      = 4'd0,
      STAGE_RESET    = 4'd1,
      STAGE_WAKING   = 4'd2,
      STAGE_NEUTRAL  = 4'd3,
      STAGE_PHASE_EN = 4'd4,
      STAGE_READY    = 4'd5,
      STAGE_RUNNING  = 4'd6,
      STAGE_STOPPING = 4'd7,
      STAGE_FAULT    = 4'd8
   } stage_type;

   typedef enum logic [2:0] {
      REQ_UPDATE   = 3'd0,
      REQ_ENABLE   = 3'd1,
      REQ_DISABLE  = 3'd2,
      REQ_RUNNING  = 3'd3,
      REQ_STOPPING = 3'd4,
      REQ_METRIC   = 3'd5
   } req_kind_type;

   typedef enum logic [2:0] {
      MET_ATTEMPTS  = 3'd0,
      MET_SUCCESSES = 3'd1,
      MET_FAULTS    = 3'd2,
      MET_RUN_FAULT = 3'd3,
      MET_WAKE_FAULT = 3'd4
   } metric_sel_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_RESET_PULSE  = 3'd0,
      CSR_WAKE_DELAY   = 3'd1,
      CSR_PHASE_DELAY  = 3'd2,
      CSR_NEUTRAL_BUFS = 3'd3,
      CSR_PHASE_COUNT  = 3'd4,
      CSR_FAULT_LOW    = 3'd5,
      CSR_USE_RESET    = 3'd6,
      CSR_SHARED_OD    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic attempt;
      logic success;
      logic fault;
      logic run_fault;
      logic wake_fault;
   } count_inc_type;

   localparam logic [2:0] MaskOne   = 3'h1;
   localparam logic [2:0] MaskTwo   = 3'h3;
   localparam logic [2:0] MaskThree = 3'h7;

   function automatic logic [2:0] phase_mask_of(input logic [1:0] count);
      logic [2:0] mask;
      unique case (count)
         2'd0:    mask = 3'h0;
         2'd1:    mask = MaskOne;
         2'd2:    mask = MaskTwo;
         default: mask = MaskThree;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

@@ design/bes_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bes_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] now_ms;
   logic [31:0] buffer_fill_count;
   logic        fault_pin;
   logic [2:0]  metric_index;

   modport source (output valid, req_type, now_ms, buffer_fill_count, fault_pin,
                   metric_index, input ready);
   modport sink (input valid, req_type, now_ms, buffer_fill_count, fault_pin,
                 metric_index, output ready);
endinterface

interface bes_rsp_if;
   logic        valid;
   logic        ready;
   logic        enable_drive;
   logic [2:0]  phase_mask;
   logic        wake_drive;
   logic        reset_drive;
   logic        is_enabled;
   logic        is_pending;
   logic        has_fault;
   logic [3:0]  stage_state;
   logic        request_accepted;
   logic        fault_report;
   logic [3:0]  fault_origin;
   logic [31:0] metric_value;

   modport source (output valid, enable_drive, phase_mask, wake_drive, reset_drive,
                   is_enabled, is_pending, has_fault, stage_state, request_accepted,
                   fault_report, fault_origin, metric_value, input ready);
   modport sink (input valid, enable_drive, phase_mask, wake_drive, reset_drive,
                 is_enabled, is_pending, has_fault, stage_state, request_accepted,
                 fault_report, fault_origin, metric_value, output ready);
endinterface

`default_nettype wire

@@ design/bes_counters.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bes_counters
   import bes_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  update,
   input  wire count_inc_type         inc,
   input  wire logic [2:0]            index,
   output logic      [CountWidth-1:0] value
);

   logic [CountWidth-1:0] count_ff [CountNum];
   logic [CountWidth-1:0] count_in [CountNum];
   logic [CountNum-1:0]   inc_vec;

   assign inc_vec = {inc.wake_fault, inc.run_fault, inc.fault, inc.success, inc.attempt};

   always_comb begin
      for (int i = 0; i < CountNum; i++) begin
         count_in[i] = count_ff[i] + CountWidth'(inc_vec[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CountNum; i++) begin
            count_ff[i] <= '0;
         end
      end else if (update) begin
         for (int i = 0; i < CountNum; i++) begin
            count_ff[i] <= count_in[i];
         end
      end
   end

   // read sees the word's own increments
   always_comb begin
      unique case (index)
         MET_ATTEMPTS:   value = count_in[0];
         MET_SUCCESSES:  value = count_in[1];
         MET_FAULTS:     value = count_in[2];
         MET_RUN_FAULT:  value = count_in[3];
         MET_WAKE_FAULT: value = count_in[4];
         default:        value = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ design/bridge_enable_sequencer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Words
// -------  ---  ------------------------------------------------------
// req      in   event: type, time, buffer count, fault pin, metric sel
// rsp      out  drives, flags, stage, report, origin, metric value
// csr      in   register write: enable, index, data
//
// One word per cycle while results are taken; results are registered.
// req_chan.ready is low only while a held result is not taken.
// Synchronous reset clears all but the result word; CSRs get defaults.

module bridge_enable_sequencer_core
   import bes_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   bes_req_if.sink                     req_chan,
   bes_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_write_enable,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [DelayWidth-1:0]  csr_write_data
);

   // register file
   logic [DelayWidth-1:0] reset_pulse_ff, wake_delay_ff, phase_delay_ff, neutral_bufs_ff;
   logic [1:0]            phase_count_ff;
   logic                  fault_low_ff, use_reset_ff, shared_od_ff;

   // sequencer state
   stage_type             stage_ff, stage_in;
   logic                  enabled_ff, enabled_in, pending_ff, pending_in;
   logic                  latch_ff, latch_in, report_ff, report_in;
   stage_type             origin_ff, origin_in;
   logic [TimeWidth-1:0]  deadline_ff, deadline_in, mark_ff, mark_in;
   logic                  drv_en_ff, drv_en_in, drv_wake_ff, drv_wake_in;
   logic                  drv_rst_ff, drv_rst_in;
   logic [2:0]            drv_ph_ff, drv_ph_in;
   logic                  last_raw_ff;

   // result word
   logic                  rsp_valid_ff;
   logic                  out_en_ff, out_wake_ff, out_rst_ff, out_enabled_ff;
   logic                  out_pending_ff, out_fault_ff, out_acc_ff, out_report_ff;
   logic [2:0]            out_ph_ff;
   stage_type             out_stage_ff, out_origin_ff;
   logic [CountWidth-1:0] out_metric_ff;

   logic                  accept;
   logic                  act;
   logic                  qual_mid, qual_out;
   logic                  accepted_v, report_v;
   logic [TimeWidth-1:0]  age;
   count_inc_type         inc;
   logic [CountWidth-1:0] count_value;
   req_kind_type          kind;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign kind           = req_kind_type'(req_chan.req_type);
   assign act            = fault_low_ff ? !req_chan.fault_pin : req_chan.fault_pin;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_pulse_ff  <= DelayWidth'(2);
         wake_delay_ff   <= DelayWidth'(2);
         phase_delay_ff  <= DelayWidth'(1);
         neutral_bufs_ff <= DelayWidth'(2);
         phase_count_ff  <= 2'd3;
         fault_low_ff    <= 1'b1;
         use_reset_ff    <= 1'b1;
         shared_od_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_RESET_PULSE:  reset_pulse_ff  <= csr_write_data;
            CSR_WAKE_DELAY:   wake_delay_ff   <= csr_write_data;
            CSR_PHASE_DELAY:  phase_delay_ff  <= csr_write_data;
            CSR_NEUTRAL_BUFS: neutral_bufs_ff <= csr_write_data;
            CSR_PHASE_COUNT:  phase_count_ff  <= csr_write_data[1:0];
            CSR_FAULT_LOW:    fault_low_ff    <= csr_write_data[0];
            CSR_USE_RESET:    use_reset_ff    <= csr_write_data[0];
            CSR_SHARED_OD:    shared_od_ff    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      stage_in    = stage_ff;
      enabled_in  = enabled_ff;
      pending_in  = pending_ff;
      latch_in    = latch_ff;
      report_in   = report_ff;
      origin_in   = origin_ff;
      deadline_in = deadline_ff;
      mark_in     = mark_ff;
      drv_en_in   = drv_en_ff;
      drv_wake_in = drv_wake_ff;
      drv_rst_in  = drv_rst_ff;
      drv_ph_in   = drv_ph_ff;
      inc         = '0;
      accepted_v  = 1'b0;
      report_v    = 1'b0;

      // fault edge
      if (act && !last_raw_ff && !(shared_od_ff && !enabled_ff && !pending_ff)) begin
         origin_in   = stage_ff;
         enabled_in  = 1'b0;
         pending_in  = 1'b0;
         latch_in    = 1'b1;
         stage_in    = STAGE_FAULT;
         drv_en_in   = 1'b0;
         drv_ph_in   = '0;
         drv_wake_in = 1'b0;
         drv_rst_in  = 1'b1;
         report_in   = 1'b1;
         inc.fault   = 1'b1;
         if (stage_ff == STAGE_RUNNING || stage_ff == STAGE_STOPPING) begin
            inc.run_fault = 1'b1;
         end else begin
            inc.wake_fault = 1'b1;
         end
      end

      qual_mid = act && !(shared_od_ff &&
                 !(stage_in == STAGE_PHASE_EN || stage_in == STAGE_READY ||
                   stage_in == STAGE_RUNNING || stage_in == STAGE_STOPPING));
      age = req_chan.now_ms - deadline_in;

      unique case (kind)
         REQ_UPDATE: begin
            if (report_in) begin
               report_in = 1'b0;
               report_v  = 1'b1;
            end else if (pending_in && !latch_in && !qual_mid) begin
               priority if (stage_in == STAGE_RESET && !age[TimeWidth-1]) begin
                  drv_rst_in  = 1'b0;
                  drv_wake_in = 1'b1;
                  stage_in    = STAGE_WAKING;
                  deadline_in = req_chan.now_ms + TimeWidth'(wake_delay_ff);
               end else if (stage_in == STAGE_WAKING && !age[TimeWidth-1]) begin
                  stage_in = STAGE_NEUTRAL;
               end else if (stage_in == STAGE_NEUTRAL &&
                            (req_chan.buffer_fill_count - mark_in) >=
                            TimeWidth'(neutral_bufs_ff)) begin
                  drv_ph_in   = phase_mask_of(phase_count_ff);
                  stage_in    = STAGE_PHASE_EN;
                  deadline_in = req_chan.now_ms + TimeWidth'(phase_delay_ff);
               end else if (stage_in == STAGE_PHASE_EN && !age[TimeWidth-1]) begin
                  drv_en_in   = 1'b1;
                  enabled_in  = 1'b1;
                  pending_in  = 1'b0;
                  stage_in    = STAGE_READY;
                  inc.success = 1'b1;
               end else begin
               end
            end
         end
         REQ_ENABLE: begin
            if (latch_in || qual_mid) begin
               enabled_in  = 1'b0;
               pending_in  = 1'b0;
               if (!latch_in) stage_in = STAGE_OFF;
               drv_en_in   = 1'b0;
               drv_ph_in   = '0;
               drv_wake_in = 1'b0;
               drv_rst_in  = 1'b1;
            end else begin
               inc.attempt = 1'b1;
               drv_en_in   = 1'b0;
               drv_ph_in   = '0;
               enabled_in  = 1'b0;
               pending_in  = 1'b1;
               mark_in     = req_chan.buffer_fill_count;
               if (use_reset_ff) begin
                  drv_rst_in  = 1'b1;
                  stage_in    = STAGE_RESET;
                  deadline_in = req_chan.now_ms + TimeWidth'(reset_pulse_ff);
               end else begin
                  drv_wake_in = 1'b1;
                  stage_in    = STAGE_WAKING;
                  deadline_in = req_chan.now_ms + TimeWidth'(wake_delay_ff);
               end
               accepted_v = 1'b1;
            end
         end
         REQ_DISABLE: begin
            enabled_in  = 1'b0;
            pending_in  = 1'b0;
            if (!latch_in) stage_in = STAGE_OFF;
            drv_en_in   = 1'b0;
            drv_ph_in   = '0;
            drv_wake_in = 1'b0;
            drv_rst_in  = 1'b1;
         end
         REQ_RUNNING: begin
            if (enabled_in && (stage_in == STAGE_READY || stage_in == STAGE_PHASE_EN)) begin
               stage_in = STAGE_RUNNING;
            end
         end
         REQ_STOPPING: begin
            if (enabled_in) stage_in = STAGE_STOPPING;
         end
         default: ;
      endcase

      qual_out = act && !(shared_od_ff &&
                 !(stage_in == STAGE_PHASE_EN || stage_in == STAGE_READY ||
                   stage_in == STAGE_RUNNING || stage_in == STAGE_STOPPING));
   end

   bes_counters u_counters (
      .clock  (clock),
      .reset  (reset),
      .update (accept),
      .inc    (inc),
      .index  (req_chan.metric_index),
      .value  (count_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= STAGE_OFF;
         enabled_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         latch_ff     <= 1'b0;
         report_ff    <= 1'b0;
         origin_ff    <= STAGE_OFF;
         deadline_ff  <= '0;
         mark_ff      <= '0;
         drv_en_ff    <= 1'b0;
         drv_ph_ff    <= '0;
         drv_wake_ff  <= 1'b0;
         drv_rst_ff   <= 1'b1;
         last_raw_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            stage_ff    <= stage_in;
            enabled_ff  <= enabled_in;
            pending_ff  <= pending_in;
            latch_ff    <= latch_in;
            report_ff   <= report_in;
            origin_ff   <= origin_in;
            deadline_ff <= deadline_in;
            mark_ff     <= mark_in;
            drv_en_ff   <= drv_en_in;
            drv_ph_ff   <= drv_ph_in;
            drv_wake_ff <= drv_wake_in;
            drv_rst_ff  <= drv_rst_in;
            last_raw_ff <= act;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_en_ff      <= drv_en_in;
         out_ph_ff      <= drv_ph_in;
         out_wake_ff    <= drv_wake_in;
         out_rst_ff     <= drv_rst_in && use_reset_ff;
         out_enabled_ff <= enabled_in;
         out_pending_ff <= pending_in;
         out_fault_ff   <= latch_in || qual_out;
         out_stage_ff   <= stage_in;
         out_acc_ff     <= accepted_v;
         out_report_ff  <= report_v;
         out_origin_ff  <= origin_in;
         out_metric_ff  <= (kind == REQ_METRIC) ? count_value : '0;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.enable_drive     = out_en_ff;
   assign rsp_chan.phase_mask       = out_ph_ff;
   assign rsp_chan.wake_drive       = out_wake_ff;
   assign rsp_chan.reset_drive      = out_rst_ff;
   assign rsp_chan.is_enabled       = out_enabled_ff;
   assign rsp_chan.is_pending       = out_pending_ff;
   assign rsp_chan.has_fault        = out_fault_ff;
   assign rsp_chan.stage_state      = out_stage_ff;
   assign rsp_chan.request_accepted = out_acc_ff;
   assign rsp_chan.fault_report     = out_report_ff;
   assign rsp_chan.fault_origin     = out_origin_ff;
   assign rsp_chan.metric_value     = out_metric_ff;

endmodule

`default_nettype wire

@@ tb/sv/bridge_enable_sequencer_core_tb.sv @@
`timescale 1ns / 1ps

module bridge_enable_sequencer_core_tb;
   import bes_pkg::*;

   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   localparam logic [2:0] METRIC_NONE   = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now;
      logic [31:0] bufs;
      logic        pin;
      logic [2:0]  midx;
   } bridge_event_type;

   typedef struct packed {
      logic        enable_drive;
      logic [2:0]  phase_mask;
      logic        wake_drive;
      logic        reset_drive;
      logic        is_enabled;
      logic        is_pending;
      logic        has_fault;
      logic [3:0]  stage_state;
      logic        request_accepted;
      logic        fault_report;
      logic [3:0]  fault_origin;
      logic [31:0] metric_value;
   } drive_status_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_enable;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [DelayWidth-1:0]  csr_write_data;

   bes_req_if req_chan ();
   bes_rsp_if rsp_chan ();

   bridge_enable_sequencer_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   bridge_event_type pending_events[$];
   drive_status_type expected_status[$];
   int unsigned      mismatches = 0;

   // sequencer state mirrored by the predictor
   logic [15:0] cfg_reset_pulse, cfg_wake_delay, cfg_phase_delay, cfg_neutral;
   logic [1:0]  cfg_phase_count;
   logic        cfg_fault_low, cfg_use_reset, cfg_shared_od;
   stage_type   seq_stage, seq_origin;
   logic        seq_enabled, seq_pending, seq_fault_latched, seq_report_due;
   logic [31:0] seq_deadline, seq_buf_mark;
   logic        drv_en, drv_wake, drv_rst;
   logic [2:0]  drv_phases;
   logic [31:0] event_count [CountNum];
   logic        seq_last_fault;

   // stimulus generator state
   logic [31:0] gen_now, gen_bufs;
   logic        gen_fault_low = 1'b1;
   logic        gen_shared_od = 1'b0;
   int unsigned phase_items;

   task automatic reset_sequencer();
      cfg_reset_pulse = 16'd2;
      cfg_wake_delay = 16'd2;
      cfg_phase_delay = 16'd1;
      cfg_neutral = 16'd2;
      cfg_phase_count = 2'd3;
      cfg_fault_low = 1'b1;
      cfg_use_reset = 1'b1;
      cfg_shared_od = 1'b0;
      seq_stage = STAGE_OFF;
      seq_origin = STAGE_OFF;
      seq_enabled = 1'b0;
      seq_pending = 1'b0;
      seq_fault_latched = 1'b0;
      seq_report_due = 1'b0;
      seq_deadline = '0;
      seq_buf_mark = '0;
      drv_en = 1'b0;
      drv_phases = '0;
      drv_wake = 1'b0;
      drv_rst = 1'b1;
      foreach (event_count[i]) event_count[i] = '0;
      seq_last_fault = 1'b0;
   endtask

   task automatic apply_register(input logic [CsrIdxWidth-1:0] idx,
                                 input logic [DelayWidth-1:0] data);
      case (idx)
         CSR_RESET_PULSE:  cfg_reset_pulse = data;
         CSR_WAKE_DELAY:   cfg_wake_delay = data;
         CSR_PHASE_DELAY:  cfg_phase_delay = data;
         CSR_NEUTRAL_BUFS: cfg_neutral = data;
         CSR_PHASE_COUNT:  cfg_phase_count = data[1:0];
         CSR_FAULT_LOW:    cfg_fault_low = data[0];
         CSR_USE_RESET:    cfg_use_reset = data[0];
         default:          cfg_shared_od = data[0];
      endcase
   endtask

   function automatic logic pin_active(input logic pin);
      return cfg_fault_low ? !pin : pin;
   endfunction

   function automatic logic fault_qualified(input logic pin);
      if (cfg_shared_od && !(seq_stage >= STAGE_PHASE_EN && seq_stage <= STAGE_STOPPING))
         return 1'b0;
      return pin_active(pin);
   endfunction

   function automatic logic deadline_hit(input logic [31:0] now);
      logic [31:0] diff;
      diff = now - seq_deadline;
      return !diff[31];
   endfunction

   function automatic logic [2:0] configured_mask();
      case (cfg_phase_count)
         2'd0:    return 3'h0;
         2'd1:    return MaskOne;
         2'd2:    return MaskTwo;
         default: return MaskThree;
      endcase
   endfunction

   task automatic drop_drives();
      drv_en = 1'b0;
      drv_phases = '0;
      drv_wake = 1'b0;
      drv_rst = 1'b1;
   endtask

   task automatic shut_down();
      seq_enabled = 1'b0;
      seq_pending = 1'b0;
      if (!seq_fault_latched) seq_stage = STAGE_OFF;
      drop_drives();
   endtask

   task automatic latch_fault();
      if (!(cfg_shared_od && !seq_enabled && !seq_pending)) begin
         seq_origin = seq_stage;
         seq_enabled = 1'b0;
         seq_pending = 1'b0;
         seq_fault_latched = 1'b1;
         seq_stage = STAGE_FAULT;
         drop_drives();
         seq_report_due = 1'b1;
         event_count[MET_FAULTS] += 1;
         if (seq_origin == STAGE_RUNNING || seq_origin == STAGE_STOPPING)
            event_count[MET_RUN_FAULT] += 1;
         else
            event_count[MET_WAKE_FAULT] += 1;
      end
   endtask

   task automatic enter_wake(input logic [31:0] now);
      drv_wake = 1'b1;
      seq_stage = STAGE_WAKING;
      seq_deadline = now + 32'(cfg_wake_delay);
   endtask

   task automatic sequence_event(input bridge_event_type w, output drive_status_type s);
      logic        accepted, report, act;
      logic [31:0] metric;
      accepted = 1'b0;
      report = 1'b0;
      metric = '0;
      act = pin_active(w.pin);
      if (act && !seq_last_fault) latch_fault();
      seq_last_fault = act;
      case (w.kind)
         REQ_UPDATE: begin
            if (seq_report_due) begin
               seq_report_due = 1'b0;
               report = 1'b1;
            end else if (seq_pending && !seq_fault_latched && !fault_qualified(w.pin)) begin
               if (seq_stage == STAGE_RESET && deadline_hit(w.now)) begin
                  drv_rst = 1'b0;
                  enter_wake(w.now);
               end else if (seq_stage == STAGE_WAKING && deadline_hit(w.now)) begin
                  seq_stage = STAGE_NEUTRAL;
               end else if (seq_stage == STAGE_NEUTRAL
                            && (w.bufs - seq_buf_mark) >= {16'd0, cfg_neutral}) begin
                  drv_phases = configured_mask();
                  seq_stage = STAGE_PHASE_EN;
                  seq_deadline = w.now + 32'(cfg_phase_delay);
               end else if (seq_stage == STAGE_PHASE_EN && deadline_hit(w.now)) begin
                  drv_en = 1'b1;
                  seq_enabled = 1'b1;
                  seq_pending = 1'b0;
                  seq_stage = STAGE_READY;
                  event_count[MET_SUCCESSES] += 1;
               end
            end
         end
         REQ_ENABLE: begin
            if (seq_fault_latched || fault_qualified(w.pin)) begin
               shut_down();
            end else begin
               event_count[MET_ATTEMPTS] += 1;
               drv_en = 1'b0;
               drv_phases = '0;
               seq_enabled = 1'b0;
               seq_pending = 1'b1;
               seq_buf_mark = w.bufs;
               if (cfg_use_reset) begin
                  drv_rst = 1'b1;
                  seq_stage = STAGE_RESET;
                  seq_deadline = w.now + 32'(cfg_reset_pulse);
               end else begin
                  enter_wake(w.now);
               end
               accepted = 1'b1;
            end
         end
         REQ_DISABLE: shut_down();
         REQ_RUNNING: begin
            if (seq_enabled && (seq_stage == STAGE_READY || seq_stage == STAGE_PHASE_EN))
               seq_stage = STAGE_RUNNING;
         end
         REQ_STOPPING: begin
            if (seq_enabled) seq_stage = STAGE_STOPPING;
         end
         REQ_METRIC: begin
            if (w.midx < CountNum) metric = event_count[w.midx];
         end
         default: ;
      endcase
      s.enable_drive = drv_en;
      s.phase_mask = drv_phases;
      s.wake_drive = drv_wake;
      s.reset_drive = drv_rst && cfg_use_reset;
      s.is_enabled = seq_enabled;
      s.is_pending = seq_pending;
      s.has_fault = seq_fault_latched || fault_qualified(w.pin);
      s.stage_state = seq_stage;
      s.request_accepted = accepted;
      s.fault_report = report;
      s.fault_origin = seq_origin;
      s.metric_value = metric;
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      drive_status_type got, want;
      bridge_event_type seen;
      if (reset) begin
         reset_sequencer();
         expected_status.delete();
      end else begin
         if (csr_write_enable) apply_register(csr_index, csr_write_data);
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.enable_drive, rsp_chan.phase_mask, rsp_chan.wake_drive,
                    rsp_chan.reset_drive, rsp_chan.is_enabled, rsp_chan.is_pending,
                    rsp_chan.has_fault, rsp_chan.stage_state, rsp_chan.request_accepted,
                    rsp_chan.fault_report, rsp_chan.fault_origin, rsp_chan.metric_value};
            if (expected_status.size() == 0) begin
               $error("status word with nothing expected");
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               check_field("enable_drive", 32'(want.enable_drive), 32'(got.enable_drive));
               check_field("phase_mask", 32'(want.phase_mask), 32'(got.phase_mask));
               check_field("wake_drive", 32'(want.wake_drive), 32'(got.wake_drive));
               check_field("reset_drive", 32'(want.reset_drive), 32'(got.reset_drive));
               check_field("is_enabled", 32'(want.is_enabled), 32'(got.is_enabled));
               check_field("is_pending", 32'(want.is_pending), 32'(got.is_pending));
               check_field("has_fault", 32'(want.has_fault), 32'(got.has_fault));
               check_field("stage_state", 32'(want.stage_state), 32'(got.stage_state));
               check_field("request_accepted", 32'(want.request_accepted),
                           32'(got.request_accepted));
               check_field("fault_report", 32'(want.fault_report), 32'(got.fault_report));
               check_field("fault_origin", 32'(want.fault_origin), 32'(got.fault_origin));
               check_field("metric_value", want.metric_value, got.metric_value);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen = '{req_chan.req_type, req_chan.now_ms, req_chan.buffer_fill_count,
                     req_chan.fault_pin, req_chan.metric_index};
            sequence_event(seen, want);
            expected_status.push_back(want);
         end
      end
   end

   int unsigned burst_left = 0;
   int unsigned gap_left = 0;

   always @(posedge clock) begin : driver
      bridge_event_type next_word;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (pending_events.size() > 0) begin
            next_word = pending_events.pop_front();
            req_chan.req_type <= next_word.kind;
            req_chan.now_ms <= next_word.now;
            req_chan.buffer_fill_count <= next_word.bufs;
            req_chan.fault_pin <= next_word.pin;
            req_chan.metric_index <= next_word.midx;
            req_chan.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               if ($urandom_range(0, 3) == 0)
                  gap_left = 0;
               else
                  gap_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 20 : 3);
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   logic [7:0]  stall_span = '0;
   int unsigned stall_mode = 0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_span = 8'($urandom_range(16, 200));
         end
         stall_span--;
         case (stall_mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: rsp_chan.ready <= stall_span[2];
         endcase
      end
   end

   task automatic queue_word(input logic [2:0] kind, input logic [31:0] now, bufs,
                             input logic pin, input logic [2:0] midx);
      bridge_event_type w;
      w = '{kind, now, bufs, pin, midx};
      pending_events.push_back(w);
      phase_items++;
   endtask

   task automatic queue_event(input logic [2:0] kind, input logic pin);
      queue_word(kind, gen_now, gen_bufs, pin, 3'($urandom_range(0, 7)));
   endtask

   task automatic advance_clock();
      case ($urandom_range(0, 15))
         0, 1, 2:     ;
         3, 4, 5, 6:  gen_now += $urandom_range(1, 4);
         7, 8, 9, 10: gen_now += $urandom_range(0, 70000);
         11, 12:      gen_now += $urandom_range(0, 1000);
         13, 14:      gen_now -= $urandom_range(1, 4);
         default:     gen_now = $urandom;
      endcase
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5, 6, 7, 8, 9: gen_bufs += $urandom_range(0, 3);
         10, 11, 12, 13, 14:           gen_bufs += $urandom_range(0, 70000);
         default:                      gen_bufs = $urandom;
      endcase
   endtask

   function automatic logic [2:0] side_kind();
      case ($urandom_range(0, 3))
         0:       return REQ_RUNNING;
         1:       return REQ_STOPPING;
         2:       return REQ_METRIC;
         default: return REQ_ENABLE;
      endcase
   endfunction

   task automatic queue_enable_run(input int unsigned length, input logic may_close);
      queue_event(REQ_ENABLE, gen_fault_low);
      repeat (length) begin
         advance_clock();
         if ($urandom_range(0, 9) == 0)
            queue_event(side_kind(), gen_fault_low);
         else
            queue_event(REQ_UPDATE, gen_fault_low);
      end
      if ($urandom_range(0, 2) != 0) queue_event(REQ_RUNNING, gen_fault_low);
      if ($urandom_range(0, 2) == 0) begin
         advance_clock();
         queue_event(REQ_STOPPING, gen_fault_low);
      end
      if ($urandom_range(0, 1) == 0) queue_event(REQ_METRIC, gen_fault_low);
      if (may_close && $urandom_range(0, 1) == 0) queue_event(REQ_DISABLE, gen_fault_low);
   endtask

   // raise the shared fault line only while idle, so the edge is masked and nothing latches
   task automatic queue_masked_burst();
      queue_event(REQ_DISABLE, gen_fault_low);
      queue_event(REQ_ENABLE, !gen_fault_low);
      repeat ($urandom_range(3, 15)) begin
         advance_clock();
         if ($urandom_range(0, 5) == 0)
            queue_event(side_kind(), !gen_fault_low);
         else
            queue_event(REQ_UPDATE, !gen_fault_low);
      end
      queue_event(REQ_DISABLE, !gen_fault_low);
      queue_event(REQ_UPDATE, gen_fault_low);
   endtask

   task automatic queue_noise(input logic pin);
      logic [2:0] kind;
      kind = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 2) == 0) kind = REQ_UPDATE;
      advance_clock();
      queue_event(kind, pin);
   endtask

   function automatic logic [15:0] pick_delay();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(0, 8));
         4:       return 16'($urandom_range(0, 300));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic write_register(input logic [CsrIdxWidth-1:0] idx,
                                 input logic [DelayWidth-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
   endtask

   task automatic configure(input logic [15:0] rp, wd, pd, nb, input logic [1:0] pc,
                            input logic fl, ur, so);
      write_register(CSR_RESET_PULSE, rp);
      write_register(CSR_WAKE_DELAY, wd);
      write_register(CSR_PHASE_DELAY, pd);
      write_register(CSR_NEUTRAL_BUFS, nb);
      write_register(CSR_PHASE_COUNT, {14'd0, pc});
      write_register(CSR_FAULT_LOW, {15'd0, fl});
      write_register(CSR_USE_RESET, {15'd0, ur});
      write_register(CSR_SHARED_OD, {15'd0, so});
      @(posedge clock);
      csr_write_enable <= 1'b0;
      gen_fault_low = fl;
      gen_shared_od = so;
      phase_items = 0;
      gen_now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
      gen_bufs = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_chan.valid || expected_status.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic fill_random_phase();
      while (phase_items < 240) begin
         case ($urandom_range(0, 9))
            0: queue_noise(gen_fault_low);
            1: begin
               if (gen_shared_od)
                  queue_masked_burst();
               else
                  queue_noise(gen_fault_low);
            end
            default: queue_enable_run($urandom_range(4, 30), 1'b1);
         endcase
      end
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_UPDATE;
      req_chan.now_ms = '0;
      req_chan.buffer_fill_count = '0;
      req_chan.fault_pin = 1'b1;
      req_chan.metric_index = MET_ATTEMPTS;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_RESET_PULSE;
      csr_write_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // walk the default settings through a full enable, across the time wrap
      phase_items = 0;
      queue_word(REQ_UPDATE, 32'd0, 32'd0, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_DISABLE, 32'd0, 32'd0, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_RUNNING, 32'd0, 32'd0, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_STOPPING, 32'd0, 32'd0, 1'b1, MET_ATTEMPTS);
      queue_word(KIND_SPARE_LO, 32'd0, 32'd0, 1'b1, MET_SUCCESSES);
      queue_word(KIND_SPARE_HI, 32'd0, 32'd0, 1'b1, METRIC_NONE);
      queue_word(REQ_ENABLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_UPDATE, 32'd0, 32'hFFFF_FFFF, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_UPDATE, 32'd1, 32'hFFFF_FFFF, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_UPDATE, 32'd2, 32'hFFFF_FFFF, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_UPDATE, 32'd3, 32'hFFFF_FFFF, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_UPDATE, 32'd3, 32'd0, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_UPDATE, 32'd3, 32'd1, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_RUNNING, 32'd3, 32'd1, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_UPDATE, 32'd4, 32'd1, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_RUNNING, 32'd4, 32'd1, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_STOPPING, 32'd4, 32'd1, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_METRIC, 32'd4, 32'd1, 1'b1, MET_ATTEMPTS);
      queue_word(REQ_METRIC, 32'd4, 32'd1, 1'b1, MET_SUCCESSES);
      queue_word(REQ_METRIC, 32'd4, 32'd1, 1'b1, MET_FAULTS);
      queue_word(REQ_METRIC, 32'd4, 32'd1, 1'b1, MET_RUN_FAULT);
      queue_word(REQ_METRIC, 32'd4, 32'd1, 1'b1, MET_WAKE_FAULT);
      queue_word(REQ_METRIC, 32'd4, 32'd1, 1'b1, METRIC_NONE);
      queue_word(REQ_DISABLE, 32'd4, 32'd1, 1'b1, MET_ATTEMPTS);
      wait_idle();

      configure(16'd0, 16'd0, 16'd0, 16'd0, 2'd0, 1'b0, 1'b0, 1'b0);
      fill_random_phase();
      wait_idle();

      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1, 1'b1, 1'b1);
      fill_random_phase();
      wait_idle();

      repeat (6) begin
         configure(pick_delay(), pick_delay(), pick_delay(), pick_delay(),
                   2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         fill_random_phase();
         wait_idle();
      end

      // the fault latch holds until reset, so fault edges come last
      configure(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      queue_enable_run($urandom_range(0, 25), 1'b0);
      advance_clock();
      queue_event(3'($urandom_range(0, 7)), !gen_fault_low);
      while (phase_items < 250) begin
         if ($urandom_range(0, 4) == 0)
            queue_enable_run($urandom_range(2, 10), 1'b1);
         else
            queue_noise(1'($urandom_range(0, 1)));
      end
      queue_word(REQ_METRIC, gen_now, gen_bufs, gen_fault_low, MET_ATTEMPTS);
      queue_word(REQ_METRIC, gen_now, gen_bufs, gen_fault_low, MET_SUCCESSES);
      queue_word(REQ_METRIC, gen_now, gen_bufs, gen_fault_low, MET_FAULTS);
      queue_word(REQ_METRIC, gen_now, gen_bufs, gen_fault_low, MET_RUN_FAULT);
      queue_word(REQ_METRIC, gen_now, gen_bufs, gen_fault_low, MET_WAKE_FAULT);
      wait_idle();
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
design/bes_pkg.sv
design/bes_if.sv
design/bes_counters.sv
design/bridge_enable_sequencer_core.sv
tb/sv/bridge_enable_sequencer_core_tb.sv
